>>> rtl/core/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, word types and pipeline bus structs of the quaternion
// vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int CompWidth  = 32;   // vector and quaternion components
   localparam int QprodWidth = 64;   // product of two quaternion parts
   localparam int CoefWidth  = 66;   // rotation matrix entry, 60 fraction bits
   localparam int ProdWidth  = 98;   // matrix entry times vector component
   localparam int SumWidth   = 100;  // sum of three products, 76 fraction bits
   localparam int FracShift  = 60;   // fraction bits dropped at the end
   localparam int Dim        = 3;

   typedef logic signed [CompWidth-1:0]  comp_type;
   typedef logic signed [QprodWidth-1:0] qprod_type;
   typedef logic signed [CoefWidth-1:0]  coef_type;
   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic signed [SumWidth-1:0]   sum_type;

   // half of one output LSB, added before the fraction bits are dropped
   localparam sum_type RoundBias = sum_type'({1'b1, {(FracShift-1){1'b0}}});

   // matrix entries, row major: coef[row*3 + col]
   typedef struct packed {
      logic                       valid;
      comp_type [Dim-1:0]         vec;
      coef_type [Dim*Dim-1:0]     coef;
   } coef_bus_type;

   typedef struct packed {
      logic                       valid;
      sum_type  [Dim-1:0]         sum;
   } sum_bus_type;

endpackage

>>> rtl/core/qvr_coef.sv
// ----------------------------------------------------------------------------
// qvr_coef
// Rotation matrix builder: ten quaternion part products, then the nine
// matrix entries of q * v * conj(q). Two register stages.
// ----------------------------------------------------------------------------
module qvr_coef (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  qvr_pkg::comp_type     vec_x,
   input  qvr_pkg::comp_type     vec_y,
   input  qvr_pkg::comp_type     vec_z,
   input  qvr_pkg::comp_type     quat_w,
   input  qvr_pkg::comp_type     quat_x,
   input  qvr_pkg::comp_type     quat_y,
   input  qvr_pkg::comp_type     quat_z,
   output qvr_pkg::coef_bus_type coef_bus
);
   import qvr_pkg::*;

   // stage 1: part products
   logic               valid1_ff;
   comp_type [Dim-1:0] vec1_ff, vec1_in;
   qprod_type aa_ff, bb_ff, cc_ff, dd_ff, ab_ff, ac_ff, ad_ff, bc_ff, bd_ff, cd_ff;
   qprod_type aa_in, bb_in, cc_in, dd_in, ab_in, ac_in, ad_in, bc_in, bd_in, cd_in;

   // stage 2: matrix entries
   coef_bus_type coef_ff, coef_in;

   always_comb begin
      vec1_in = {vec_z, vec_y, vec_x};
      aa_in   = quat_w * quat_w;
      bb_in   = quat_x * quat_x;
      cc_in   = quat_y * quat_y;
      dd_in   = quat_z * quat_z;
      ab_in   = quat_w * quat_x;
      ac_in   = quat_w * quat_y;
      ad_in   = quat_w * quat_z;
      bc_in   = quat_x * quat_y;
      bd_in   = quat_x * quat_z;
      cd_in   = quat_y * quat_z;
   end

   always_comb begin
      coef_in.valid   = valid1_ff;
      coef_in.vec     = vec1_ff;
      coef_in.coef[0] = coef_type'(aa_ff) + coef_type'(bb_ff)
                        - coef_type'(cc_ff) - coef_type'(dd_ff);
      coef_in.coef[1] = (coef_type'(bc_ff) - coef_type'(ad_ff)) <<< 1;
      coef_in.coef[2] = (coef_type'(bd_ff) + coef_type'(ac_ff)) <<< 1;
      coef_in.coef[3] = (coef_type'(bc_ff) + coef_type'(ad_ff)) <<< 1;
      coef_in.coef[4] = coef_type'(aa_ff) + coef_type'(cc_ff)
                        - coef_type'(bb_ff) - coef_type'(dd_ff);
      coef_in.coef[5] = (coef_type'(cd_ff) - coef_type'(ab_ff)) <<< 1;
      coef_in.coef[6] = (coef_type'(bd_ff) - coef_type'(ac_ff)) <<< 1;
      coef_in.coef[7] = (coef_type'(cd_ff) + coef_type'(ab_ff)) <<< 1;
      coef_in.coef[8] = coef_type'(aa_ff) + coef_type'(dd_ff)
                        - coef_type'(bb_ff) - coef_type'(cc_ff);
   end

   // data advances every cycle; only the valid bits see reset
   always_ff @(posedge clock) begin
      vec1_ff      <= vec1_in;
      aa_ff        <= aa_in;
      bb_ff        <= bb_in;
      cc_ff        <= cc_in;
      dd_ff        <= dd_in;
      ab_ff        <= ab_in;
      ac_ff        <= ac_in;
      ad_ff        <= ad_in;
      bc_ff        <= bc_in;
      bd_ff        <= bd_in;
      cd_ff        <= cd_in;
      coef_ff.vec  <= coef_in.vec;
      coef_ff.coef <= coef_in.coef;
      if (reset) begin
         valid1_ff     <= 1'b0;
         coef_ff.valid <= 1'b0;
      end else begin
         valid1_ff     <= in_valid;
         coef_ff.valid <= coef_in.valid;
      end
   end

   assign coef_bus = coef_ff;

endmodule

>>> rtl/core/qvr_mac.sv
// ----------------------------------------------------------------------------
// qvr_mac
// Matrix times vector: 32-bit partial products of each entry, their
// recombination, and the row sums with the rounding bias. Three stages.
// ----------------------------------------------------------------------------
module qvr_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  qvr_pkg::coef_bus_type coef_bus,
   output qvr_pkg::sum_bus_type  sum_bus
);
   import qvr_pkg::*;

   localparam int Entries = Dim * Dim;
   localparam int LoWidth = CompWidth + CompWidth + 1;           // 33 x 32
   localparam int HiWidth = CoefWidth - 2*CompWidth + CompWidth; // 2 x 32

   // stage 3: partial products of the low, middle and top slices
   logic                              valid3_ff;
   logic signed [LoWidth-1:0]         pp_lo_ff  [Entries];
   logic signed [LoWidth-1:0]         pp_lo_in  [Entries];
   logic signed [LoWidth-1:0]         pp_mid_ff [Entries];
   logic signed [LoWidth-1:0]         pp_mid_in [Entries];
   logic signed [HiWidth-1:0]         pp_hi_ff  [Entries];
   logic signed [HiWidth-1:0]         pp_hi_in  [Entries];

   // stage 4: full products
   logic     valid4_ff;
   prod_type prod_ff [Entries];
   prod_type prod_in [Entries];

   // stage 5: row sums
   sum_bus_type sum_ff, sum_in;

   always_comb begin
      for (int r = 0; r < Dim; r++) begin
         for (int c = 0; c < Dim; c++) begin
            pp_lo_in[r*Dim+c]  = $signed({1'b0, coef_bus.coef[r*Dim+c][CompWidth-1:0]})
                                 * $signed(coef_bus.vec[c]);
            pp_mid_in[r*Dim+c] = $signed({1'b0,
                                   coef_bus.coef[r*Dim+c][2*CompWidth-1:CompWidth]})
                                 * $signed(coef_bus.vec[c]);
            pp_hi_in[r*Dim+c]  = $signed(coef_bus.coef[r*Dim+c][CoefWidth-1:2*CompWidth])
                                 * $signed(coef_bus.vec[c]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < Entries; k++) begin
         prod_in[k] = (prod_type'(pp_hi_ff[k]) <<< (2*CompWidth))
                      + (prod_type'(pp_mid_ff[k]) <<< CompWidth)
                      + prod_type'(pp_lo_ff[k]);
      end
   end

   always_comb begin
      sum_in.valid = valid4_ff;
      for (int r = 0; r < Dim; r++) begin
         sum_in.sum[r] = sum_type'(prod_ff[r*Dim])
                         + sum_type'(prod_ff[r*Dim+1])
                         + sum_type'(prod_ff[r*Dim+2])
                         + RoundBias;
      end
   end

   // data advances every cycle; only the valid bits see reset
   always_ff @(posedge clock) begin
      pp_lo_ff   <= pp_lo_in;
      pp_mid_ff  <= pp_mid_in;
      pp_hi_ff   <= pp_hi_in;
      prod_ff    <= prod_in;
      sum_ff.sum <= sum_in.sum;
      if (reset) begin
         valid3_ff    <= 1'b0;
         valid4_ff    <= 1'b0;
         sum_ff.valid <= 1'b0;
      end else begin
         valid3_ff    <= coef_bus.valid;
         valid4_ff    <= valid3_ff;
         sum_ff.valid <= sum_in.valid;
      end
   end

   assign sum_bus = sum_ff;

endmodule

>>> rtl/core/qvr_round.sv
// ----------------------------------------------------------------------------
// qvr_round
// Output stage: drop the fraction bits, saturate each component to 32 bits
// and flag any clipping. Registers drive the result ports.
// ----------------------------------------------------------------------------
module qvr_round (
   input  logic                 clock,
   input  logic                 reset,
   input  qvr_pkg::sum_bus_type sum_bus,
   output logic                 out_strobe,
   output qvr_pkg::comp_type    out_x,
   output qvr_pkg::comp_type    out_y,
   output qvr_pkg::comp_type    out_z,
   output logic                 out_clipped
);
   import qvr_pkg::*;

   localparam int KeepWidth = SumWidth - FracShift;

   logic                      strobe_ff;
   comp_type [Dim-1:0]        rot_ff, rot_in;
   logic                      clipped_ff, clipped_in;
   logic [Dim-1:0]            over;
   logic signed [KeepWidth-1:0] kept [Dim];

   always_comb begin
      for (int r = 0; r < Dim; r++) begin
         kept[r] = sum_bus.sum[r][SumWidth-1:FracShift];
         // top bits must all match the 32-bit sign bit
         over[r] = !((&kept[r][KeepWidth-1:CompWidth-1])
                     || (~|kept[r][KeepWidth-1:CompWidth-1]));
         if (over[r]) begin
            rot_in[r] = kept[r][KeepWidth-1] ? {1'b1, {(CompWidth-1){1'b0}}}
                                             : {1'b0, {(CompWidth-1){1'b1}}};
         end else begin
            rot_in[r] = kept[r][CompWidth-1:0];
         end
      end
      clipped_in = |over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= sum_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      rot_ff     <= rot_in;
      clipped_ff <= clipped_in;
   end

   assign out_strobe  = strobe_ff;
   assign out_x       = rot_ff[0];
   assign out_y       = rot_ff[1];
   assign out_z       = rot_ff[2];
   assign out_clipped = clipped_ff;

endmodule

>>> rtl/core/quaternion_vector_rotate_top.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top
// Rotates a Q16.16 vector by a quaternion with 30 fraction bits, as the
// vector part of q * v * conj(q), rounded once and saturated.
// ----------------------------------------------------------------------------
// Pulse start with a word on the req_ ports; the word is taken at any edge
// where busy is low. busy is high only during reset, so a new word
// can enter on every cycle. Each word gives exactly one result, shown
// on the rsp_ ports for a single cycle with rsp_strobe high, in order.
// There is no way to hold results back: capture them on the strobe.
// Each word passes six register stages on its way from the req_
// ports to the rsp_ ports, in this order: quaternion part
// products, matrix entries, 32-bit partial products of entry times vector,
// their recombination, the row sums with the rounding bias, and the final
// saturation. The math is exact up to the last step; a non-unit quaternion
// scales the vector by its squared norm. Halves round toward plus infinity
// and rsp_clipped flags any component that hit the 32-bit limits.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qvr_pkg::comp_type req_vec_x,
   input  qvr_pkg::comp_type req_vec_y,
   input  qvr_pkg::comp_type req_vec_z,
   input  qvr_pkg::comp_type req_quat_w,
   input  qvr_pkg::comp_type req_quat_x,
   input  qvr_pkg::comp_type req_quat_y,
   input  qvr_pkg::comp_type req_quat_z,
   output logic              rsp_strobe,
   output qvr_pkg::comp_type rsp_rot_x,
   output qvr_pkg::comp_type rsp_rot_y,
   output qvr_pkg::comp_type rsp_rot_z,
   output logic              rsp_clipped
);
   import qvr_pkg::*;

   logic         accept;
   coef_bus_type coef_bus;
   sum_bus_type  sum_bus;

   // the pipeline never stalls; refuse words only while in reset
   assign busy   = reset;
   assign accept = start & ~busy;

   // stages 1-2: build the rotation matrix
   qvr_coef u_coef (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .vec_x    (req_vec_x),
      .vec_y    (req_vec_y),
      .vec_z    (req_vec_z),
      .quat_w   (req_quat_w),
      .quat_x   (req_quat_x),
      .quat_y   (req_quat_y),
      .quat_z   (req_quat_z),
      .coef_bus (coef_bus)
   );

   // stages 3-5: multiply matrix by vector, add rounding bias
   qvr_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .coef_bus (coef_bus),
      .sum_bus  (sum_bus)
   );

   // stage 6: drop fraction, saturate, drive result ports
   qvr_round u_round (
      .clock       (clock),
      .reset       (reset),
      .sum_bus     (sum_bus),
      .out_strobe  (rsp_strobe),
      .out_x       (rsp_rot_x),
      .out_y       (rsp_rot_y),
      .out_z       (rsp_rot_z),
      .out_clipped (rsp_clipped)
   );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quaternion_vector_rotate_top. A short table of
// hand-picked words (identity, zero, full-scale quaternion, exact halves,
// saturation both ways) runs first. About 850 random words follow, drawn
// from full-range, scaled, coarse-grid and corner-value mixes. Every response
// is checked in order against a typed value or a bit-exact 128-bit predictor.
// ----------------------------------------------------------------------------
module tb;
   import qvr_pkg::*;

   typedef logic signed [127:0] wide_t;

   // one request word: vector in Q16.16, quaternion with 30 fraction bits
   typedef struct packed {
      comp_type vx, vy, vz;
      comp_type qw, qx, qy, qz;
   } rot_word_t;

   typedef struct packed {
      comp_type x, y, z;
      logic     clip;
   } rot_out_t;

   // stimulus table row; typed rows carry a hand-computed response
   typedef struct packed {
      rot_word_t word;
      bit        typed;
      rot_out_t  want;
   } dir_row_t;

   localparam comp_type CompMax   = 32'sh7FFF_FFFF;
   localparam comp_type CompMin   = 32'sh8000_0000;
   localparam comp_type QuatOne   = 32'sh4000_0000;   // 1.0 with 30 fraction bits
   localparam comp_type QuatHalf  = 32'sh2000_0000;   // 0.5
   localparam wide_t    RoundHalf = wide_t'(1) <<< (FracShift - 1);
   localparam wide_t    SatHigh   = wide_t'(CompMax);
   localparam wide_t    SatLow    = wide_t'(CompMin);
   localparam int       RandomWords = 850;
   localparam int       StallLimit  = 1000;
   localparam int       TailCycles  = 12;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   comp_type req_vec_x, req_vec_y, req_vec_z;
   comp_type req_quat_w, req_quat_x, req_quat_y, req_quat_z;
   logic     rsp_strobe;
   comp_type rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic     rsp_clipped;

   rot_out_t pending_rotations [$];
   dir_row_t directed_rows [$];
   int       error_count = 0;
   int       stall_cycles = 0;

   quaternion_vector_rotate_top uut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Bit-exact rotation: build the rotation matrix from the quaternion part
   // products, multiply by the vector, add half an LSB, drop 60 fraction
   // bits (floor), then clamp each component to 32 bits.
   function automatic rot_out_t rotate_by_quat(rot_word_t w);
      wide_t    a, b, c, d;
      wide_t    aa, bb, cc, dd, ab, ac, ad, bc, bd, cd;
      wide_t    v [3];
      wide_t    m [9];
      wide_t    acc;
      comp_type res [3];
      logic     clip;
      rot_out_t r;
      a = w.qw;
      b = w.qx;
      c = w.qy;
      d = w.qz;
      v[0] = w.vx;
      v[1] = w.vy;
      v[2] = w.vz;
      aa = a * a;  bb = b * b;  cc = c * c;  dd = d * d;
      ab = a * b;  ac = a * c;  ad = a * d;
      bc = b * c;  bd = b * d;  cd = c * d;
      m[0] = aa + bb - cc - dd;
      m[1] = (bc - ad) <<< 1;
      m[2] = (bd + ac) <<< 1;
      m[3] = (bc + ad) <<< 1;
      m[4] = aa + cc - bb - dd;
      m[5] = (cd - ab) <<< 1;
      m[6] = (bd - ac) <<< 1;
      m[7] = (cd + ab) <<< 1;
      m[8] = aa + dd - bb - cc;
      clip = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = m[3*i] * v[0] + m[3*i+1] * v[1] + m[3*i+2] * v[2] + RoundHalf;
         acc = acc >>> FracShift;
         if (acc > SatHigh) begin
            res[i] = CompMax;
            clip   = 1'b1;
         end else if (acc < SatLow) begin
            res[i] = CompMin;
            clip   = 1'b1;
         end else begin
            res[i] = acc[31:0];
         end
      end
      r.x    = res[0];
      r.y    = res[1];
      r.z    = res[2];
      r.clip = clip;
      return r;
   endfunction

   function automatic comp_type corner_value();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 1;
         2:       return -1;
         3:       return CompMax;
         4:       return CompMin;
         5:       return QuatOne;
         6:       return -QuatOne;
         default: return QuatHalf;
      endcase
   endfunction

   // Mix of word shapes: full 32-bit noise, scaled magnitudes that mostly
   // stay in range, a coarse grid that lands on exact halves, and corners.
   function automatic rot_word_t random_word();
      rot_word_t w;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         end
         4, 5, 6: begin
            w.vx = comp_type'($urandom) >>> $urandom_range(0, 20);
            w.vy = comp_type'($urandom) >>> $urandom_range(0, 20);
            w.vz = comp_type'($urandom) >>> $urandom_range(0, 20);
            w.qw = comp_type'($urandom) >>> $urandom_range(1, 6);
            w.qx = comp_type'($urandom) >>> $urandom_range(1, 6);
            w.qy = comp_type'($urandom) >>> $urandom_range(1, 6);
            w.qz = comp_type'($urandom) >>> $urandom_range(1, 6);
         end
         7: begin
            w.vx = comp_type'(int'($urandom_range(0, 64)) - 32);
            w.vy = comp_type'(int'($urandom_range(0, 64)) - 32);
            w.vz = comp_type'(int'($urandom_range(0, 64)) - 32);
            w.qw = comp_type'(int'($urandom_range(0, 8)) - 4) <<< 28;
            w.qx = comp_type'(int'($urandom_range(0, 8)) - 4) <<< 28;
            w.qy = comp_type'(int'($urandom_range(0, 8)) - 4) <<< 28;
            w.qz = comp_type'(int'($urandom_range(0, 8)) - 4) <<< 28;
         end
         default: begin
            w.vx = $urandom_range(0, 1) ? corner_value() : comp_type'($urandom);
            w.vy = $urandom_range(0, 1) ? corner_value() : comp_type'($urandom);
            w.vz = $urandom_range(0, 1) ? corner_value() : comp_type'($urandom);
            w.qw = $urandom_range(0, 1) ? corner_value() : comp_type'($urandom);
            w.qx = $urandom_range(0, 1) ? corner_value() : comp_type'($urandom);
            w.qy = $urandom_range(0, 1) ? corner_value() : comp_type'($urandom);
            w.qz = $urandom_range(0, 1) ? corner_value() : comp_type'($urandom);
         end
      endcase
      return w;
   endfunction

   function automatic void add_row(rot_word_t w, bit typed, rot_out_t want);
      dir_row_t row;
      row.word  = w;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // Idle start for gap cycles, then present the word and hold it until an
   // edge with busy low takes it. Start stays high on return so that a
   // back-to-back word needs no second assignment in the same step.
   task automatic send_word(input rot_word_t w, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_vec_x  <= w.vx;
      req_vec_y  <= w.vy;
      req_vec_z  <= w.vz;
      req_quat_w <= w.qw;
      req_quat_x <= w.qx;
      req_quat_y <= w.qy;
      req_quat_z <= w.qz;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
   endtask

   // Drop start and hold off until every outstanding response has come.
   task automatic drain_rotations();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_rotations.size() != 0);
   endtask

   // Response checker: the block cannot be stalled, so capture every strobe
   // and compare it with the oldest outstanding expectation.
   always @(posedge clock) begin : check_rsp
      rot_out_t want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rotations.size() == 0) begin
            $display("%0t: response with none outstanding: x=%0d y=%0d z=%0d clip=%b",
                     $time, rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_clipped);
            error_count++;
         end else begin
            want = pending_rotations.pop_front();
            if (rsp_rot_x !== want.x) begin
               $display("%0t: rot_x expected %0d, got %0d", $time, want.x, rsp_rot_x);
               error_count++;
            end
            if (rsp_rot_y !== want.y) begin
               $display("%0t: rot_y expected %0d, got %0d", $time, want.y, rsp_rot_y);
               error_count++;
            end
            if (rsp_rot_z !== want.z) begin
               $display("%0t: rot_z expected %0d, got %0d", $time, want.z, rsp_rot_z);
               error_count++;
            end
            if (rsp_clipped !== want.clip) begin
               $display("%0t: clipped expected %b, got %b", $time, want.clip, rsp_clipped);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count edges where no word goes in and no response comes out.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= StallLimit) begin
            $display("%0t: no progress for %0d cycles", $time, StallLimit);
            $display("quaternion_vector_rotate_top verification failed");
            $finish;
         end
      end
   end

   initial begin
      rot_word_t w;
      int        gap;
      bit        burst;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_vec_x  <= '0;
      req_vec_y  <= '0;
      req_vec_z  <= '0;
      req_quat_w <= '0;
      req_quat_x <= '0;
      req_quat_y <= '0;
      req_quat_z <= '0;

      // identity quaternion passes the vector through unchanged
      add_row('{1, 2, 3, QuatOne, 0, 0, 0}, 1'b1, '{1, 2, 3, 0});
      add_row('{CompMax, CompMin, 0, QuatOne, 0, 0, 0}, 1'b1, '{CompMax, CompMin, 0, 0});
      add_row('{0, 0, 0, QuatOne, 0, 0, 0}, 1'b1, '{0, 0, 0, 0});
      // zero quaternion collapses any vector
      add_row('{CompMax, CompMin, CompMax, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0});
      // w = -2.0 scales by |q|^2 = 4, clamping at both rails
      add_row('{1, 2, 3, CompMin, 0, 0, 0}, 1'b1, '{4, 8, 12, 0});
      add_row('{CompMax, CompMin, 0, CompMin, 0, 0, 0}, 1'b1, '{CompMax, CompMin, 0, 1});
      add_row('{CompMin, CompMax, 1, CompMin, 0, 0, 0}, 1'b1, '{CompMin, CompMax, 4, 1});
      // 90 degrees about x at half scale: exact halves round up
      add_row('{1, 1, 1, QuatHalf, QuatHalf, 0, 0}, 1'b1, '{1, 0, 1, 0});
      add_row('{-1, 1, 3, QuatHalf, QuatHalf, 0, 0}, 1'b1, '{0, -1, 1, 0});
      // 180 degrees about x
      add_row('{5, 6, 7, 0, QuatOne, 0, 0}, 1'b1, '{5, -6, -7, 0});
      // remaining extremes go through the predictor
      add_row('{CompMax, CompMax, CompMax, CompMin, CompMin, CompMin, CompMin}, 1'b0, '0);
      add_row('{CompMin, CompMin, CompMin, CompMax, CompMax, CompMax, CompMax}, 1'b0, '0);
      add_row('{-1, -1, -1, -1, -1, -1, -1}, 1'b0, '0);
      add_row('{CompMin, CompMax, CompMin, 0, 0, QuatOne, 0}, 1'b0, '0);
      add_row('{1, 1, 1, 0, 0, 0, CompMin}, 1'b0, '0);
      add_row('{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_FFFF,
                CompMax, CompMin, CompMax, CompMin}, 1'b0, '0);
      add_row('{32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
                QuatHalf, -QuatHalf, QuatHalf, -QuatHalf}, 1'b0, '0);
      add_row('{CompMax, 0, CompMin, QuatOne, QuatOne, QuatOne, QuatOne}, 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: typed rows use their written-in response
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word, $urandom_range(0, 4));
         pending_rotations.push_back(directed_rows[i].typed ? directed_rows[i].want
                                                            : rotate_by_quat(directed_rows[i].word));
      end
      drain_rotations();

      // random words; every 50 words decide whether to run a gap-free burst
      burst = 1'b0;
      for (int i = 0; i < RandomWords; i++) begin
         if (i % 50 == 0)
            burst = ($urandom_range(0, 2) == 0);
         if (i == RandomWords / 2)
            drain_rotations();
         gap = burst ? 0 : $urandom_range(0, 4);
         w = random_word();
         send_word(w, gap);
         pending_rotations.push_back(rotate_by_quat(w));
      end

      // let the pipeline empty, then keep watching for stray responses
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_rotations.size() != 0);
      repeat (TailCycles) @(posedge clock);

      if (error_count == 0)
         $display("quaternion_vector_rotate_top verification clean");
      else
         $display("quaternion_vector_rotate_top verification failed");
      $finish;
   end

endmodule
